>>> design/crc16_length_frame_packer_macros.svh
// assertion macros for the length-prefixed frame packer
// empty bodies when SYNTHESIS is defined
`ifndef CRC16_LENGTH_FRAME_PACKER_MACROS_SVH
`define CRC16_LENGTH_FRAME_PACKER_MACROS_SVH
`ifndef SYNTHESIS
// condition implies consequence in the same cycle
`define CLFP_ASSERT_IMPLY(label, clk, rst, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error("frame packer check failed");
// condition implies consequence in the next cycle
`define CLFP_ASSERT_NEXT(label, clk, rst, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error("frame packer check failed");
`else
`define CLFP_ASSERT_IMPLY(label, clk, rst, cond, conseq)
`define CLFP_ASSERT_NEXT(label, clk, rst, cond, conseq)
`endif
`endif

>>> design/clfp_pkg.sv
// shared types, constants and crc function for the frame packer
// no dependencies
`default_nettype none
package clfp_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LEN_W     = 16;
  localparam int unsigned CRC_W     = 16;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
  localparam logic [CRC_W-1:0] CRC_TOP  = 16'h8000;

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = 2;
  localparam int unsigned Q_CNT_W = 3;

  localparam logic OP_HEADER  = 1'b0;
  localparam logic OP_PAYLOAD = 1'b1;

  localparam logic KIND_HDR  = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_BYTE   = 8'd1;

  typedef struct packed {
    logic              kind;
    logic              close;
    logic [BYTE_W-1:0] first;
    logic [LEN_W-1:0]  len;
    logic [CRC_W-1:0]  crc;
  } job_t;

  function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != '0) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> design/clfp_front.sv
// front end: accepts items, tracks the open frame and its running crc
// pushes one job per item that produces bytes; uses clfp_pkg
`default_nettype none
module clfp_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          accept,
  input  wire logic                          opcode,
  input  wire logic [clfp_pkg::BYTE_W-1:0]   command,
  input  wire logic [clfp_pkg::LEN_W-1:0]    frame_length,
  input  wire logic [clfp_pkg::BYTE_W-1:0]   data_byte,
  output logic                               push,
  output clfp_pkg::job_t                     push_job,
  output logic                               frame_open,
  output logic [clfp_pkg::LEN_W-1:0]         bytes_left
);

  logic [clfp_pkg::CRC_W-1:0] crc_acc;
  logic [clfp_pkg::CRC_W-1:0] crc_acc_next;
  logic [clfp_pkg::LEN_W-1:0] bytes_left_next;
  logic                       frame_open_next;
  logic [clfp_pkg::CRC_W-1:0] hdr_crc;
  logic [clfp_pkg::CRC_W-1:0] dat_crc;
  logic                       is_hdr;
  logic                       last_byte;

  assign is_hdr    = (opcode == clfp_pkg::OP_HEADER);
  assign hdr_crc   = clfp_pkg::crc_feed(clfp_pkg::crc_feed(clfp_pkg::crc_feed(
                       clfp_pkg::CRC_INIT, command), frame_length[15:8]), frame_length[7:0]);
  assign dat_crc   = clfp_pkg::crc_feed(crc_acc, data_byte);
  assign last_byte = (bytes_left == clfp_pkg::LEN_W'(1));

  always_comb begin
    crc_acc_next    = crc_acc;
    bytes_left_next = bytes_left;
    frame_open_next = frame_open;
    push            = 1'b0;
    push_job.kind   = is_hdr ? clfp_pkg::KIND_HDR : clfp_pkg::KIND_DATA;
    push_job.first  = is_hdr ? command : data_byte;
    push_job.len    = frame_length;
    push_job.crc    = is_hdr ? hdr_crc : dat_crc;
    push_job.close  = is_hdr ? (frame_length == '0) : last_byte;
    if (accept) begin
      if (is_hdr) begin
        push = 1'b1;
        if (frame_length == '0) begin
          crc_acc_next    = clfp_pkg::CRC_INIT;
          bytes_left_next = '0;
          frame_open_next = 1'b0;
        end else begin
          crc_acc_next    = hdr_crc;
          bytes_left_next = frame_length;
          frame_open_next = 1'b1;
        end
      end else if (frame_open) begin
        push = 1'b1;
        if (last_byte) begin
          crc_acc_next    = clfp_pkg::CRC_INIT;
          bytes_left_next = '0;
          frame_open_next = 1'b0;
        end else begin
          crc_acc_next    = dat_crc;
          bytes_left_next = bytes_left - clfp_pkg::LEN_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_acc    <= clfp_pkg::CRC_INIT;
      bytes_left <= '0;
      frame_open <= 1'b0;
    end else begin
      crc_acc    <= crc_acc_next;
      bytes_left <= bytes_left_next;
      frame_open <= frame_open_next;
    end
  end

endmodule
`default_nettype wire

>>> design/clfp_queue.sv
// job queue between front and back ends
// small register queue with count; uses clfp_pkg
`default_nettype none
module clfp_queue (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  input  clfp_pkg::job_t                     push_job,
  input  wire logic                          pop,
  output clfp_pkg::job_t                     head,
  output logic                               empty,
  output logic                               full,
  output logic [clfp_pkg::Q_CNT_W-1:0]       count
);

  clfp_pkg::job_t                 slots [clfp_pkg::Q_DEPTH];
  logic [clfp_pkg::Q_PTR_W-1:0]   wr_ptr;
  logic [clfp_pkg::Q_PTR_W-1:0]   rd_ptr;
  logic                           do_push;
  logic                           do_pop;

  assign empty   = (count == '0);
  assign full    = (count == clfp_pkg::Q_CNT_W'(clfp_pkg::Q_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + clfp_pkg::Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + clfp_pkg::Q_PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + clfp_pkg::Q_CNT_W'(1);
        2'b01:   count <= count - clfp_pkg::Q_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> design/clfp_back.sv
// back end: serializes the head job into frame bytes, one per cycle while result_stall is low
// registered output stage; uses clfp_pkg
`default_nettype none
module clfp_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  clfp_pkg::job_t                     head,
  input  wire logic                          empty,
  input  wire logic [clfp_pkg::BYTE_W-1:0]   start_byte,
  input  wire logic [clfp_pkg::BYTE_W-1:0]   end_byte,
  output logic                               pop,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output logic [clfp_pkg::BYTE_W-1:0]        out_byte,
  output logic                               frame_end
);

  localparam logic [2:0] POS_START  = 3'd0;
  localparam logic [2:0] POS_FIRST  = 3'd1;
  localparam logic [2:0] POS_LEN_HI = 3'd2;
  localparam logic [2:0] POS_LEN_LO = 3'd3;
  localparam logic [2:0] POS_CRC_HI = 3'd4;
  localparam logic [2:0] POS_CRC_LO = 3'd5;
  localparam logic [2:0] POS_END    = 3'd6;

  logic [2:0]                  step;
  logic [2:0]                  pos;
  logic [2:0]                  last_step;
  logic                        load;
  logic                        fire;
  logic [clfp_pkg::BYTE_W-1:0] sel_byte;

  assign load = !result_valid || !result_stall;
  assign fire = load && !empty;
  assign pop  = fire && (step == last_step);

  always_comb begin
    if (head.kind == clfp_pkg::KIND_HDR) begin
      pos       = step;
      last_step = head.close ? 3'd6 : 3'd3;
    end else begin
      pos       = (step == 3'd0) ? POS_FIRST : step + 3'd3;
      last_step = head.close ? 3'd3 : 3'd0;
    end
    case (pos)
      POS_START:  sel_byte = start_byte;
      POS_FIRST:  sel_byte = head.first;
      POS_LEN_HI: sel_byte = head.len[15:8];
      POS_LEN_LO: sel_byte = head.len[7:0];
      POS_CRC_HI: sel_byte = head.crc[15:8];
      POS_CRC_LO: sel_byte = head.crc[7:0];
      POS_END:    sel_byte = end_byte;
      default:    sel_byte = end_byte;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      step         <= '0;
    end else begin
      if (load) begin
        result_valid <= !empty;
      end
      if (fire) begin
        step <= (step == last_step) ? 3'd0 : step + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte  <= sel_byte;
      frame_end <= (pos == POS_END);
    end
  end

endmodule
`default_nettype wire

>>> design/crc16_length_frame_packer.sv
// Length-prefixed frame packer with CRC-16/CCITT-FALSE. A header item
// (opcode 0) produces start byte, command and big-endian length; a payload
// item (opcode 1) produces its byte; the item that completes a frame (or a
// header with zero length) also produces the big-endian crc and the end byte,
// marked by frame_end. Payload with no open frame is dropped, and a header
// abandons any open frame. Items are taken one per cycle, unless the queue is
// full, into a four-entry job queue; the output delivers one frame byte per
// cycle while result_stall is low; an item yields 0 to 7 bytes, and the
// sustained input rate follows that byte count. No clearing pass after reset.
// depends on clfp_pkg, clfp_front, clfp_queue, clfp_back and the macro header
`default_nettype none
`include "crc16_length_frame_packer_macros.svh"
module crc16_length_frame_packer (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              item_valid,
  output logic                                   item_stall,
  input  wire logic                              opcode,
  input  wire logic [clfp_pkg::BYTE_W-1:0]       command,
  input  wire logic [clfp_pkg::LEN_W-1:0]        frame_length,
  input  wire logic [clfp_pkg::BYTE_W-1:0]       data_byte,
  output logic                                   result_valid,
  input  wire logic                              result_stall,
  output logic [clfp_pkg::BYTE_W-1:0]            out_byte,
  output logic                                   frame_end,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [clfp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [clfp_pkg::BYTE_W-1:0]       cfg_data
);

  logic [clfp_pkg::BYTE_W-1:0]  start_byte;
  logic [clfp_pkg::BYTE_W-1:0]  end_byte;
  logic                         accept;
  logic                         push;
  clfp_pkg::job_t               push_job;
  clfp_pkg::job_t               head;
  logic                         pop;
  logic                         empty;
  logic                         full;
  logic [clfp_pkg::Q_CNT_W-1:0] count;
  logic                         frame_open;
  logic [clfp_pkg::LEN_W-1:0]   bytes_left;

  assign cfg_ready  = 1'b1;
  assign item_stall = full;
  assign accept     = item_valid && !item_stall;

  // configuration transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= '0;
      end_byte   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        clfp_pkg::REG_START_BYTE: start_byte <= cfg_data;
        clfp_pkg::REG_END_BYTE:   end_byte   <= cfg_data;
        default:                  start_byte <= start_byte;
      endcase
    end
  end

  clfp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .opcode       (opcode),
    .command      (command),
    .frame_length (frame_length),
    .data_byte    (data_byte),
    .push         (push),
    .push_job     (push_job),
    .frame_open   (frame_open),
    .bytes_left   (bytes_left)
  );

  clfp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full),
    .count    (count)
  );

  clfp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (empty),
    .start_byte   (start_byte),
    .end_byte     (end_byte),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_byte     (out_byte),
    .frame_end    (frame_end)
  );

  `CLFP_ASSERT_IMPLY(a_count_bound, clk, rst, 1'b1, count <= clfp_pkg::Q_CNT_W'(clfp_pkg::Q_DEPTH))
  `CLFP_ASSERT_IMPLY(a_open_has_left, clk, rst, frame_open, bytes_left != '0)
  `CLFP_ASSERT_IMPLY(a_end_value, clk, rst, result_valid && frame_end, out_byte == end_byte)
  `CLFP_ASSERT_NEXT(a_push_lands, clk, rst, push && !pop, !empty)

endmodule
`default_nettype wire

>>> dv/tb_crc16_length_frame_packer.sv
// self-checking testbench for crc16_length_frame_packer: directed table, then random frames
// under several start/end byte settings, with random idles on both channels
// depends on clfp_pkg and the crc16_length_frame_packer rtl
`timescale 1ns / 100ps
module tb_crc16_length_frame_packer;

  localparam int DRAIN_CYCLES = 32;
  localparam logic [3:0] NO_LIT = 4'hF;

  typedef struct packed {
    logic [7:0] octet;
    logic       closes;
  } frame_byte_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                      kind;
    logic [clfp_pkg::CFG_IDX_W-1:0] reg_idx;
    logic [7:0]                     reg_val;
    logic                           op;
    logic [7:0]                     cmd;
    logic [15:0]                    flen;
    logic [7:0]                     dbyte;
    logic [3:0]                     lit_cnt;
    logic [2:0]                     lit_n;
    logic [31:0]                    lit;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic opcode = clfp_pkg::OP_HEADER;
  logic [7:0] command = 8'h00;
  logic [15:0] frame_length = 16'h0000;
  logic [7:0] data_byte = 8'h00;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [7:0] out_byte;
  logic frame_end;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [clfp_pkg::CFG_IDX_W-1:0] cfg_index = clfp_pkg::REG_START_BYTE;
  logic [7:0] cfg_data = 8'h00;

  crc16_length_frame_packer dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .opcode(opcode), .command(command), .frame_length(frame_length), .data_byte(data_byte),
    .result_valid(result_valid), .result_stall(result_stall),
    .out_byte(out_byte), .frame_end(frame_end),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("crc16_length_frame_packer test failed");
    $finish;
  end

  // frame state mirrored from the block
  logic [7:0]  cfg_start = 8'h00;
  logic [7:0]  cfg_end = 8'h00;
  logic [15:0] run_crc = clfp_pkg::CRC_INIT;
  logic [15:0] pay_left = 16'h0000;
  logic        in_frame = 1'b0;

  frame_byte_t wire_q[$];
  frame_byte_t fresh[7];
  stim_row_t   dir_tab[$];
  int          mismatches = 0;
  int          live_items = 0;
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;
  int          rx_hold = 0;

  function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    logic fb;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r = {r[14:0], 1'b0};
      if (fb) r = r ^ clfp_pkg::CRC_POLY;
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic emit(input logic [7:0] b, input logic last, inout int n);
    frame_byte_t e;
    e.octet = b;
    e.closes = last;
    wire_q.push_back(e);
    fresh[n] = e;
    n++;
  endtask

  task automatic close_frame(inout int n);
    emit(run_crc[15:8], 1'b0, n);
    emit(run_crc[7:0], 1'b0, n);
    emit(cfg_end, 1'b1, n);
    run_crc = clfp_pkg::CRC_INIT;
    pay_left = 16'h0000;
    in_frame = 1'b0;
  endtask

  task automatic pack_frame_item(input logic op, input logic [7:0] cmd, input logic [15:0] flen,
                                 input logic [7:0] dbyte, output int produced);
    produced = 0;
    if (op == clfp_pkg::OP_HEADER) begin
      run_crc = crc_step(crc_step(crc_step(clfp_pkg::CRC_INIT, cmd), flen[15:8]), flen[7:0]);
      emit(cfg_start, 1'b0, produced);
      emit(cmd, 1'b0, produced);
      emit(flen[15:8], 1'b0, produced);
      emit(flen[7:0], 1'b0, produced);
      if (flen == 16'h0000) begin
        close_frame(produced);
      end else begin
        pay_left = flen;
        in_frame = 1'b1;
      end
      return;
    end
    if (!in_frame) return;
    run_crc = crc_step(run_crc, dbyte);
    emit(dbyte, 1'b0, produced);
    pay_left = pay_left - 16'h0001;
    if (pay_left == 16'h0000) close_frame(produced);
  endtask

  task automatic send_item(input logic op, input logic [7:0] cmd, input logic [15:0] flen,
                           input logic [7:0] dbyte, output int produced);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid   <= 1'b1;
    opcode       <= op;
    command      <= cmd;
    frame_length <= flen;
    data_byte    <= dbyte;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    pack_frame_item(op, cmd, flen, dbyte, produced);
    if (produced > 0) live_items++;
  endtask

  task automatic write_reg(input logic [clfp_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
    item_valid <= 1'b0;
    while (wire_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == clfp_pkg::REG_START_BYTE) cfg_start = val;
    else if (idx == clfp_pkg::REG_END_BYTE) cfg_end = val;
  endtask

  // well-formed frames mostly, with stray payloads and truncated frames mixed in
  task automatic send_frame();
    int r;
    int q;
    int n_pay;
    int produced;
    logic [15:0] flen;
    logic [7:0] cmd;
    r = $urandom_range(0, 99);
    tx_steady = ($urandom_range(0, 7) == 0);
    if (r < 10) begin
      send_item(clfp_pkg::OP_PAYLOAD, 8'($urandom), 16'($urandom), 8'($urandom), produced);
      return;
    end
    q = $urandom_range(0, 99);
    if (q < 15) flen = 16'h0000;
    else if (q < 70) flen = 16'($urandom_range(1, 6));
    else if (q < 90) flen = 16'($urandom_range(7, 24));
    else flen = 16'($urandom);
    n_pay = int'(flen);
    if (n_pay > 24) n_pay = $urandom_range(0, 8);
    else if (r < 22 && n_pay != 0) n_pay = $urandom_range(0, n_pay - 1);
    cmd = 8'($urandom);
    send_item(clfp_pkg::OP_HEADER, cmd, flen, 8'($urandom), produced);
    repeat (n_pay) begin
      send_item(clfp_pkg::OP_PAYLOAD, 8'($urandom), 16'($urandom), 8'($urandom), produced);
    end
  endtask

  function automatic stim_row_t item_row(input logic op, input logic [7:0] cmd,
                                         input logic [15:0] flen, input logic [7:0] dbyte,
                                         input logic [3:0] cnt, input logic [2:0] n,
                                         input logic [31:0] lit);
    stim_row_t s;
    s = '0;
    s.kind = ROW_ITEM;
    s.op = op;
    s.cmd = cmd;
    s.flen = flen;
    s.dbyte = dbyte;
    s.lit_cnt = cnt;
    s.lit_n = n;
    s.lit = lit;
    return s;
  endfunction

  function automatic stim_row_t cfg_row(input logic [clfp_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [7:0] val);
    stim_row_t s;
    s = '0;
    s.kind = ROW_CFG;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  always @(posedge clk) begin
    frame_byte_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (wire_q.size() == 0) begin
          $error("unexpected transaction: out_byte=%02h frame_end=%0b", out_byte, frame_end);
          mismatches++;
        end else begin
          want = wire_q.pop_front();
          if (out_byte !== want.octet) begin
            $error("out_byte: expected %02h, actual %02h", want.octet, out_byte);
            mismatches++;
          end
          if (frame_end !== want.closes) begin
            $error("frame_end: expected %0b, actual %0b", want.closes, frame_end);
            mismatches++;
          end
        end
      end
      if ($urandom_range(0, 199) == 0) rx_steady <= !rx_steady;
      if (rx_hold != 0) begin
        result_stall <= 1'b1;
        rx_hold <= rx_hold - 1;
      end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
        result_stall <= 1'b1;
        rx_hold <= pick_gap();
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  initial begin
    int produced;
    int phase_goal;
    logic [7:0] want_b;
    logic [7:0] s_val;
    logic [7:0] e_val;

    // reset values, stray payload, zero length, extremes, restart, close
    dir_tab.push_back(item_row(clfp_pkg::OP_PAYLOAD, 8'h00, 16'h0000, 8'hFF, 4'd0, 3'd0, 32'h0));
    dir_tab.push_back(item_row(clfp_pkg::OP_HEADER, 8'h00, 16'h0000, 8'h00,
                               4'd7, 3'd4, 32'h00000000));
    dir_tab.push_back(item_row(clfp_pkg::OP_HEADER, 8'hFF, 16'hFFFF, 8'hFF,
                               4'd4, 3'd4, 32'h00FFFFFF));
    dir_tab.push_back(item_row(clfp_pkg::OP_PAYLOAD, 8'hFF, 16'hFFFF, 8'h00,
                               4'd1, 3'd1, 32'h00000000));
    dir_tab.push_back(item_row(clfp_pkg::OP_PAYLOAD, 8'h00, 16'h0000, 8'hFF,
                               4'd1, 3'd1, 32'hFF000000));
    dir_tab.push_back(item_row(clfp_pkg::OP_HEADER, 8'hA5, 16'h0001, 8'h00,
                               4'd4, 3'd4, 32'h00A50001));
    dir_tab.push_back(item_row(clfp_pkg::OP_PAYLOAD, 8'h00, 16'h0000, 8'h5A,
                               4'd4, 3'd1, 32'h5A000000));
    dir_tab.push_back(item_row(clfp_pkg::OP_PAYLOAD, 8'hFF, 16'hFFFF, 8'h33, 4'd0, 3'd0, 32'h0));
    dir_tab.push_back(cfg_row(clfp_pkg::REG_START_BYTE, 8'hFF));
    dir_tab.push_back(cfg_row(clfp_pkg::REG_END_BYTE, 8'hFF));
    dir_tab.push_back(item_row(clfp_pkg::OP_HEADER, 8'h3C, 16'h0100, 8'h00,
                               4'd4, 3'd4, 32'hFF3C0100));
    dir_tab.push_back(item_row(clfp_pkg::OP_HEADER, 8'h12, 16'h0003, 8'hC3, NO_LIT, 3'd0, 32'h0));
    dir_tab.push_back(item_row(clfp_pkg::OP_PAYLOAD, 8'h00, 16'h0000, 8'h01,
                               NO_LIT, 3'd0, 32'h0));
    dir_tab.push_back(item_row(clfp_pkg::OP_PAYLOAD, 8'h00, 16'h0000, 8'h80,
                               NO_LIT, 3'd0, 32'h0));
    dir_tab.push_back(item_row(clfp_pkg::OP_PAYLOAD, 8'h00, 16'h0000, 8'h7F,
                               NO_LIT, 3'd0, 32'h0));
    dir_tab.push_back(item_row(clfp_pkg::OP_HEADER, 8'h00, 16'h0000, 8'h00,
                               4'd7, 3'd4, 32'hFF000000));
    dir_tab.push_back(cfg_row(clfp_pkg::REG_START_BYTE, 8'h00));
    dir_tab.push_back(item_row(clfp_pkg::OP_HEADER, 8'h80, 16'h0002, 8'h00, NO_LIT, 3'd0, 32'h0));
    dir_tab.push_back(item_row(clfp_pkg::OP_PAYLOAD, 8'h00, 16'h0000, 8'h55,
                               NO_LIT, 3'd0, 32'h0));
    dir_tab.push_back(item_row(clfp_pkg::OP_PAYLOAD, 8'h00, 16'h0000, 8'hAA,
                               NO_LIT, 3'd0, 32'h0));
    dir_tab.push_back(item_row(clfp_pkg::OP_HEADER, 8'h01, 16'h8000, 8'h00,
                               4'd4, 3'd4, 32'h00018000));
    dir_tab.push_back(item_row(clfp_pkg::OP_HEADER, 8'h7F, 16'h00FF, 8'h00,
                               4'd4, 3'd4, 32'h007F00FF));
    dir_tab.push_back(item_row(clfp_pkg::OP_PAYLOAD, 8'h00, 16'h0000, 8'hC3,
                               4'd1, 3'd1, 32'hC3000000));
    dir_tab.push_back(item_row(clfp_pkg::OP_HEADER, 8'h5A, 16'h0000, 8'h00, NO_LIT, 3'd0, 32'h0));
    dir_tab.push_back(cfg_row(clfp_pkg::REG_END_BYTE, 8'h00));
    dir_tab.push_back(item_row(clfp_pkg::OP_HEADER, 8'h00, 16'h0001, 8'h00,
                               4'd4, 3'd4, 32'h00000001));
    dir_tab.push_back(item_row(clfp_pkg::OP_PAYLOAD, 8'h00, 16'h0000, 8'h00,
                               NO_LIT, 3'd0, 32'h0));

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
      end else begin
        send_item(dir_tab[i].op, dir_tab[i].cmd, dir_tab[i].flen, dir_tab[i].dbyte, produced);
        if (dir_tab[i].lit_cnt != NO_LIT) begin
          if (produced != int'(dir_tab[i].lit_cnt)) begin
            $error("result count: expected %0d, actual %0d", dir_tab[i].lit_cnt, produced);
            mismatches++;
          end
          for (int k = 0; k < int'(dir_tab[i].lit_n) && k < produced; k++) begin
            want_b = dir_tab[i].lit[31 - 8 * k -: 8];
            if (fresh[k].octet !== want_b) begin
              $error("out_byte: expected %02h, actual %02h", want_b, fresh[k].octet);
              mismatches++;
            end
          end
        end
      end
    end

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          s_val = 8'h00;
          e_val = 8'hFF;
        end
        1: begin
          s_val = 8'hFF;
          e_val = 8'h00;
        end
        default: begin
          s_val = 8'($urandom);
          e_val = 8'($urandom);
        end
      endcase
      write_reg(clfp_pkg::REG_START_BYTE, s_val);
      write_reg(clfp_pkg::REG_END_BYTE, e_val);
      phase_goal = live_items + 100;
      while (live_items < phase_goal) send_frame();
    end

    item_valid <= 1'b0;
    while (wire_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("crc16_length_frame_packer test passed");
    end else begin
      $display("crc16_length_frame_packer test failed");
    end
    $finish;
  end

endmodule
